// File: src/dab_pkg.sv
// ----------------------------------------------------------------------------
// dab_pkg: shared types and constants for the decrement-and-branch unit
// Item layouts, condition select codes and field geometry.
// ----------------------------------------------------------------------------
package dab_pkg;

  localparam int unsigned RegNumW = 5;
  localparam int unsigned SelW    = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned DispW   = 16;

  // Sequential step to the next instruction
  localparam logic [DataW-1:0] SeqStep = 32'd4;

  // Condition select codes (mode byte bits 7..5)
  localparam logic [SelW-1:0] SelOv     = 3'd0;
  localparam logic [SelW-1:0] SelCy     = 3'd1;
  localparam logic [SelW-1:0] SelZ      = 3'd2;
  localparam logic [SelW-1:0] SelCyOrZ  = 3'd3;
  localparam logic [SelW-1:0] SelS      = 3'd4;
  localparam logic [SelW-1:0] SelTest   = 3'd5;
  localparam logic [SelW-1:0] SelLt     = 3'd6;
  localparam logic [SelW-1:0] SelLe     = 3'd7;

  // Opcode group: second table inverts the condition
  localparam logic OpFirst  = 1'b0;
  localparam logic OpSecond = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [7:0]              mode_byte;
    logic [DataW-1:0]        reg_value;
    logic [DataW-1:0]        current_pc;
    logic signed [DispW-1:0] displacement;
    logic                    flag_sign;
    logic                    flag_overflow;
    logic                    flag_zero;
    logic                    flag_carry;
  } dab_in_t;

  typedef struct packed {
    logic [RegNumW-1:0] reg_number;
    logic [DataW-1:0]   new_reg_value;
    logic               reg_write;
    logic               branch_taken;
    logic [DataW-1:0]   next_pc;
  } dab_out_t;

  typedef struct packed {
    logic sign;
    logic overflow;
    logic zero;
    logic carry;
  } dab_flags_t;

endpackage

// File: src/dab_cond.sv
// ----------------------------------------------------------------------------
// dab_cond: condition evaluation
// Picks one of eight flag conditions by select code.
// ----------------------------------------------------------------------------
module dab_cond (
  input  logic [dab_pkg::SelW-1:0] sel_i,
  input  dab_pkg::dab_flags_t      flags_i,
  output logic                     cond_o
);

  logic lt;

  assign lt = flags_i.sign ^ flags_i.overflow;

  always_comb begin
    case (sel_i)
      dab_pkg::SelOv:    cond_o = flags_i.overflow;
      dab_pkg::SelCy:    cond_o = flags_i.carry;
      dab_pkg::SelZ:     cond_o = flags_i.zero;
      dab_pkg::SelCyOrZ: cond_o = flags_i.carry | flags_i.zero;
      dab_pkg::SelS:     cond_o = flags_i.sign;
      dab_pkg::SelTest:  cond_o = 1'b1;
      dab_pkg::SelLt:    cond_o = lt;
      dab_pkg::SelLe:    cond_o = lt | flags_i.zero;
      default:           cond_o = 1'b0;
    endcase
  end

endmodule

// File: src/dab_exec.sv
// ----------------------------------------------------------------------------
// dab_exec: decrement, branch decision and next-pc computation
// Single-pass logic between the input and result registers.
// ----------------------------------------------------------------------------
module dab_exec (
  input  dab_pkg::dab_in_t  item_i,
  output dab_pkg::dab_out_t res_o
);

  logic [dab_pkg::SelW-1:0]  sel;
  logic                      is_test;
  logic                      cond;
  logic                      cond_pol;
  logic [dab_pkg::DataW-1:0] dec_val;
  logic                      taken;
  logic [dab_pkg::DataW-1:0] disp_ext;
  dab_pkg::dab_flags_t       flags;

  assign sel     = item_i.mode_byte[7:5];
  assign is_test = (item_i.op == dab_pkg::OpSecond) && (sel == dab_pkg::SelTest);

  assign flags.sign     = item_i.flag_sign;
  assign flags.overflow = item_i.flag_overflow;
  assign flags.zero     = item_i.flag_zero;
  assign flags.carry    = item_i.flag_carry;

  dab_cond u_cond (
    .sel_i   (sel),
    .flags_i (flags),
    .cond_o  (cond)
  );

  // Second table inverts the sense of the condition
  assign cond_pol = cond ^ (item_i.op == dab_pkg::OpSecond);
  assign dec_val  = item_i.reg_value - 32'd1;

  // Test-branch jumps on a zero register; otherwise on a nonzero decrement with cond_pol
  assign taken = is_test ? (item_i.reg_value == '0)
                         : ((dec_val != '0) && cond_pol);

  assign disp_ext = {{(dab_pkg::DataW - dab_pkg::DispW){item_i.displacement[dab_pkg::DispW-1]}},
                     item_i.displacement};

  assign res_o.reg_number    = item_i.mode_byte[dab_pkg::RegNumW-1:0];
  assign res_o.new_reg_value = is_test ? item_i.reg_value : dec_val;
  assign res_o.reg_write     = ~is_test;
  assign res_o.branch_taken  = taken;
  assign res_o.next_pc       = item_i.current_pc + (taken ? disp_ext : dab_pkg::SeqStep);

endmodule

// File: src/decrement_and_branch_unit_top.sv
// ----------------------------------------------------------------------------
// decrement_and_branch_unit_top: decrement-and-branch execute unit
// Registers an instruction item, evaluates it in one pass and strobes the result.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                        Handshake
//  --------  ---------------------------  ---------------------------------
//  input     in_item_i                    taken when start_i & ~busy_o
//  result    result_o                     shown one cycle with done_o
//
//  Each item yields exactly one result, via the input and result registers.
//  One item may be taken every cycle; the ready flag, the input register
//  and the result register are the only state, and the path between the
//  last two is a compare, a decrement and one 32-bit add.
//  busy_o is high only while in reset and until the ready flag is set after release.
//  The receiver cannot stall: results are never held back.
//
module decrement_and_branch_unit_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  dab_pkg::dab_in_t   in_item_i,
  output logic               done_o,
  output dab_pkg::dab_out_t  result_o
);

  logic              rdy_q;
  logic              in_vld_q;
  dab_pkg::dab_in_t  in_item_q;
  logic              res_vld_q;
  dab_pkg::dab_out_t res_q;
  dab_pkg::dab_out_t res_d;
  logic              accept;

  // Hold off items until the ready flag is set after reset is released
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_q <= 1'b0;
    end else begin
      rdy_q <= 1'b1;
    end
  end

  assign busy_o = ~rdy_q;
  assign accept = start_i & rdy_q;

  // Input register: load the item on accept and tag it with a valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
  end

  dab_exec u_exec (
    .item_i (in_item_q),
    .res_o  (res_d)
  );

  // Result register: strobe for exactly one cycle per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = res_vld_q;
  assign result_o = res_q;

endmodule

// File: src/dab_checker.sv
// ----------------------------------------------------------------------------
// dab_port_checks: port-level checks for the decrement-and-branch unit
// Watches item timing and result consistency at the top-level ports.
// ----------------------------------------------------------------------------
module dab_port_checks (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_i,
  input dab_pkg::dab_in_t  in_item_i,
  input logic              done_i,
  input dab_pkg::dab_out_t result_i
);

  logic acc;

  assign acc = start_i & ~busy_i;

  // Every taken item produces a result after the input and result registers
  a_acc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##2 done_i)
    else $error("item taken without result");

  // No result appears without a matching earlier taken item
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(acc, 2))
    else $error("result without item");

  // Register number follows the item's mode byte
  a_reg_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |->
      (result_i.reg_number == $past(in_item_i.mode_byte[dab_pkg::RegNumW-1:0], 2)))
    else $error("register number mismatch");

  // Fall-through goes to the next sequential instruction
  a_seq_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && !result_i.branch_taken) |->
      (result_i.next_pc == $past(in_item_i.current_pc, 2) + dab_pkg::SeqStep))
    else $error("fall-through pc mismatch");

  // Test-branch writes nothing and jumps exactly on a zero register
  a_test_br: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && !result_i.reg_write) |->
      (result_i.branch_taken == (result_i.new_reg_value == '0)))
    else $error("test-branch decision mismatch");

endmodule

bind decrement_and_branch_unit_top dab_port_checks u_dab_port_checks (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start_i   (start_i),
  .busy_i    (busy_o),
  .in_item_i (in_item_i),
  .done_i    (done_o),
  .result_i  (result_o)
);
